// ===== rtl/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

  // Heap size and the widths that follow from it.
  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);

  // Payload field widths.
  localparam int VALUE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_FIELD_W = VALUE_W + STATUS_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Request kinds carried on in_tuser.
  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_EXTRACTED = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_DN_L,
    ST_DN_R,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/max_heap_priority_queue_top.sv =====
// Channel   Ports                              Content
// in        in_tvalid/in_tready/in_tuser/      request: kind on tuser, value on tdata
//           in_tdata
// out       out_tvalid/out_tready/out_tdata    result: value, status, entry count
//
// A refused request goes straight to the output state and loads the result register once it is free.
// An insert compares the rising value with one parent at a time, then writes it into its final hole.
// An extract reads the root and the last entry, then compares the hole with its left child and,
// where one exists, its right child in turn, as the heap RAM has a single read port. The block
// takes the next request only once it is back in idle. Reset empties the heap at once; the
// RAM is not cleared. A result may wait in the output register while the next request is
// worked; the sequencer then holds in its output state until that register is free.
`default_nettype none

module max_heap_priority_queue_top
  import mhpq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic                   in_tuser,   // req_type
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // value
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata   // result_value, status, entry_count, pad
);

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [VALUE_W-1:0]     val_r, val_nxt;
  logic [VALUE_W-1:0]     child_r, child_nxt;
  logic                   big_l_r, big_l_nxt;
  logic [VALUE_W-1:0]     result_r, result_nxt;
  status_t                status_r, status_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               in_xfer;
  logic               out_free;
  logic [VALUE_W-1:0] cmp_a, cmp_b;
  logic               a_less_b;
  logic [SLOT_W:0]    lc_w, rc_w, cnt_ext, nlc_w;
  logic               rc_ok;
  logic [SLOT_W-1:0]  up_ns, dn_ns;
  logic               dn_move;
  logic [VALUE_W-1:0] dn_wdata;
  logic               nlc_ok;

  // Slot number (1-based) to RAM address.
  function automatic logic [ADDR_W-1:0] to_addr(input logic [SLOT_W:0] s);
    logic [SLOT_W:0] t;
    t = s - 1'b1;
    return t[ADDR_W-1:0];
  endfunction

  mhpq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;

  // Shared signed comparator: a parent against the rising value, or a node against a child.
  always_comb begin
    case (state_r)
      ST_UP: begin
        cmp_a = ram_rdata;
        cmp_b = val_r;
      end
      ST_DN_L: begin
        cmp_a = val_r;
        cmp_b = ram_rdata;
      end
      default: begin
        cmp_a = child_r;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign a_less_b = $signed(cmp_a) < $signed(cmp_b);

  // Child slots of the hole and the bounds checks against the heap size.
  assign lc_w    = {slot_r, 1'b0};
  assign rc_w    = {slot_r, 1'b1};
  assign cnt_ext = {1'b0, count_r};
  assign rc_ok   = rc_w <= cnt_ext;
  assign up_ns   = slot_r >> 1;

  // Sift-down move decision: which child, if any, rises into the hole.
  always_comb begin
    dn_move  = 1'b0;
    dn_ns    = lc_w[SLOT_W-1:0];
    dn_wdata = ram_rdata;
    if (state_r == ST_DN_L) begin
      dn_move = a_less_b;
    end else if (a_less_b) begin
      dn_move = 1'b1;
      dn_ns   = rc_w[SLOT_W-1:0];
    end else if (big_l_r) begin
      dn_move  = 1'b1;
      dn_wdata = child_r;
    end
  end

  assign nlc_w  = {dn_ns, 1'b0};
  assign nlc_ok = nlc_w <= cnt_ext;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == REQ_INSERT) begin
            if (count_r == SLOT_W'(CAPACITY)) begin
              state_nxt = ST_OUT;
            end else if (count_r != '0) begin
              state_nxt = ST_UP;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            state_nxt = (count_r == '0) ? ST_OUT : ST_EX_ROOT;
          end
        end
      end
      ST_UP: begin
        if (!a_less_b || up_ns == SLOT_W'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_EX_ROOT: begin
        state_nxt = ST_EX_LAST;
      end
      ST_EX_LAST: begin
        state_nxt = (count_r > SLOT_W'(2)) ? ST_DN_L : ST_FIN;
      end
      ST_DN_L: begin
        if (rc_ok) begin
          state_nxt = ST_DN_R;
        end else if (dn_move && nlc_ok) begin
          state_nxt = ST_DN_L;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DN_R: begin
        state_nxt = (dn_move && nlc_ok) ? ST_DN_L : ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and output register loading.
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    val_nxt        = val_r;
    child_nxt      = child_r;
    big_l_nxt      = big_l_r;
    result_nxt     = result_r;
    status_nxt     = status_r;
    ram_we         = 1'b0;
    ram_waddr      = to_addr({1'b0, slot_r});
    ram_wdata      = ram_rdata;
    ram_raddr      = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          result_nxt = '0;
          val_nxt    = in_tdata;
          if (in_tuser == REQ_INSERT) begin
            if (count_r == SLOT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
            end else begin
              status_nxt = STAT_INSERTED;
              count_nxt  = count_r + 1'b1;
              slot_nxt   = count_r + 1'b1;
              ram_raddr  = to_addr({2'b00, count_nxt[SLOT_W-1:1]});
            end
          end else begin
            status_nxt = (count_r == '0) ? STAT_EMPTY : STAT_EXTRACTED;
          end
        end
      end
      ST_UP: begin
        // The parent is smaller: it moves down into the hole.
        if (a_less_b) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          slot_nxt  = up_ns;
          ram_raddr = to_addr({2'b00, up_ns[SLOT_W-1:1]});
        end
      end
      ST_EX_ROOT: begin
        result_nxt = ram_rdata;
        ram_raddr  = to_addr({1'b0, count_r});
      end
      ST_EX_LAST: begin
        val_nxt   = ram_rdata;
        count_nxt = count_r - 1'b1;
        slot_nxt  = SLOT_W'(1);
        ram_raddr = to_addr((SLOT_W + 1)'(2));
      end
      ST_DN_L: begin
        child_nxt = a_less_b ? ram_rdata : val_r;
        big_l_nxt = a_less_b;
        if (rc_ok) begin
          ram_raddr = to_addr(rc_w);
        end else if (dn_move) begin
          ram_we    = 1'b1;
          ram_wdata = dn_wdata;
          slot_nxt  = dn_ns;
          ram_raddr = to_addr(nlc_w);
        end
      end
      ST_DN_R: begin
        if (dn_move) begin
          ram_we    = 1'b1;
          ram_wdata = dn_wdata;
          slot_nxt  = dn_ns;
          ram_raddr = to_addr(nlc_w);
        end
      end
      ST_FIN: begin
        // The carried value settles in the final hole.
        ram_we    = 1'b1;
        ram_wdata = val_r;
      end
      ST_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, COUNT_W'(count_r), status_r, result_r};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    val_r       <= val_nxt;
    child_r     <= child_nxt;
    big_l_r     <= big_l_nxt;
    result_r    <= result_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== rtl/mhpq_checker.sv =====
`default_nettype none

module mhpq_checker
  import mhpq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   in_tuser,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  assign out_status = out_tdata[VALUE_W +: STATUS_W];
  assign out_count  = out_tdata[VALUE_W + STATUS_W +: COUNT_W];

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One request is worked at a time: the block is busy right after a transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // A refusal for a full heap reports a full count, and one for an empty heap a zero count.
  a_refusal_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status != STAT_FULL || out_count == COUNT_W'(CAPACITY)) &&
                   (out_status != STAT_EMPTY || out_count == '0))
    else $error("refusal with inconsistent entry count");

  // A refused request or an insert carries a zero result value, and the count never passes capacity.
  a_refusal_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == STAT_FULL || out_status == STAT_EMPTY || out_status == STAT_INSERTED)
    |-> out_tdata[VALUE_W-1:0] == '0 && out_count <= COUNT_W'(CAPACITY))
    else $error("nonzero value on a result without extraction");

endmodule

bind max_heap_priority_queue_top mhpq_checker u_mhpq_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mhpq_pkg::*;

  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MIX_ITEMS      = 20;
  localparam int HOLD_AT        = 8;
  localparam int DRAIN_ITEMS    = 16;
  localparam int TAIL_CYCLES    = 64;

  localparam logic signed [VALUE_W-1:0] KEY_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] KEY_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // One result as the block reports it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [COUNT_W-1:0]        count;
  } heap_result_t;

  // One row of the directed table.
  typedef struct {
    req_t               kind;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    heap_result_t       result;
  } req_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic                   in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow heap with 1-based slots and its fill level.
  logic signed [VALUE_W-1:0] heap_model [1:CAPACITY];
  int                        heap_fill;
  int                        peak_fill;

  heap_result_t pending_results[$];
  req_row_t     directed_rows[$];

  bit quiet;
  bit hold_req;
  int stall_left;
  int sent_items;
  int failures;
  int n_inserted, n_extracted, n_full, n_empty;

  max_heap_priority_queue_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow heap and return the result it yields.
  function automatic heap_result_t predict_request(req_t kind, logic signed [VALUE_W-1:0] v);
    heap_result_t              r;
    int                        slot, lc, rc, big;
    bit                        settled;
    logic signed [VALUE_W-1:0] tmp;
    r.value  = '0;
    r.status = STAT_INSERTED;
    if (kind == REQ_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        heap_fill++;
        heap_model[heap_fill] = v;
        slot = heap_fill;
        // Climb while the parent is strictly smaller.
        while (slot > 1 && heap_model[slot >> 1] < heap_model[slot]) begin
          tmp                   = heap_model[slot >> 1];
          heap_model[slot >> 1] = heap_model[slot];
          heap_model[slot]      = tmp;
          slot                  = slot >> 1;
        end
        r.status = STAT_INSERTED;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.value       = heap_model[1];
        heap_model[1] = heap_model[heap_fill];
        heap_fill--;
        slot    = 1;
        settled = 1'b0;
        // Descend toward the larger child; the left child wins a tie.
        while (!settled) begin
          lc  = 2 * slot;
          rc  = lc + 1;
          big = slot;
          if (lc <= heap_fill && heap_model[big] < heap_model[lc]) big = lc;
          if (rc <= heap_fill && heap_model[big] < heap_model[rc]) big = rc;
          if (big == slot) begin
            settled = 1'b1;
          end else begin
            tmp              = heap_model[slot];
            heap_model[slot] = heap_model[big];
            heap_model[big]  = tmp;
            slot             = big;
          end
        end
        r.status = STAT_EXTRACTED;
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    r.count = COUNT_W'(heap_fill);
    return r;
  endfunction

  function automatic req_row_t mk_row(req_t kind, logic [VALUE_W-1:0] v, bit typed,
                                      logic [VALUE_W-1:0] rv, status_t rs, int rc);
    req_row_t row;
    row.kind          = kind;
    row.value         = v;
    row.typed         = typed;
    row.result.value  = rv;
    row.result.status = rs;
    row.result.count  = COUNT_W'(rc);
    return row;
  endfunction

  // Values mix full-range noise, tight clusters that force ties, and the extremes.
  function automatic logic [VALUE_W-1:0] rand_key();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = {$urandom, $urandom};
      2: v = VALUE_W'($signed($urandom_range(0, 15)) - 8);
      default: begin
        case ($urandom_range(0, 3))
          0: v = KEY_MAX - VALUE_W'($urandom_range(0, 3));
          1: v = KEY_MIN + VALUE_W'($urandom_range(0, 3));
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offer one request, wait for its transfer, then record what it should yield.
  task automatic send_request(req_t kind, logic [VALUE_W-1:0] v, bit typed,
                              heap_result_t typed_result);
    heap_result_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = v;
    do @(posedge clk); while (!in_tready);
    predicted = predict_request(kind, v);
    pending_results.push_back(typed ? typed_result : predicted);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_random(req_t kind);
    send_request(kind, rand_key(), 1'b0, '0);
  endtask

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        stall_left = LONG_HOLD - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest pending expectation.
  always @(posedge clk) begin
    heap_result_t want;
    logic [VALUE_W-1:0] got_value;
    logic [STATUS_W-1:0] got_status;
    logic [COUNT_W-1:0] got_count;
    if (rst_n && out_tvalid && out_tready) begin
      got_value  = out_tdata[VALUE_W-1:0];
      got_status = out_tdata[VALUE_W +: STATUS_W];
      got_count  = out_tdata[VALUE_W+STATUS_W +: COUNT_W];
      case (status_t'(got_status))
        STAT_INSERTED:  n_inserted++;
        STAT_EXTRACTED: n_extracted++;
        STAT_FULL:      n_full++;
        default:        n_empty++;
      endcase
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result value=%h status=%0d count=%0d",
                   $realtime, got_value, got_status, got_count);
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value || got_status !== want.status ||
            got_count !== want.count) begin
          failures++;
          if (failures <= 10)
            $display("%0t: mismatch value %h/%h status %0d/%0d count %0d/%0d (want/got)",
                     $realtime, want.value, got_value, want.status, got_status,
                     want.count, got_count);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    heap_fill  = 0;
    peak_fill  = 0;
    sent_items = 0;
    failures   = 0;
    n_inserted = 0;
    n_extracted = 0;
    n_full     = 0;
    n_empty    = 0;

    // Directed table: empty refusals, extremes, ties, then a full drain.
    directed_rows.push_back(mk_row(REQ_EXTRACT, '0, 1, '0, STAT_EMPTY, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, KEY_MAX, 1, '0, STAT_INSERTED, 1));
    directed_rows.push_back(mk_row(REQ_EXTRACT, '1, 1, KEY_MAX, STAT_EXTRACTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, KEY_MIN, 1, '0, STAT_INSERTED, 1));
    directed_rows.push_back(mk_row(REQ_EXTRACT, '0, 1, KEY_MIN, STAT_EXTRACTED, 0));
    directed_rows.push_back(mk_row(REQ_EXTRACT, '1, 1, '0, STAT_EMPTY, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, '1, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, '0, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, 64'h5555_5555_5555_5555, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, 64'h5555_5555_5555_5555, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, KEY_MIN, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, KEY_MAX, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, 64'd5, 0, '0, STAT_INSERTED, 0));
    directed_rows.push_back(mk_row(REQ_INSERT, 64'd5, 0, '0, STAT_INSERTED, 0));
    for (int i = 0; i < 9; i++)
      directed_rows.push_back(mk_row(REQ_EXTRACT, '0, 0, '0, STAT_EXTRACTED, 0));
    directed_rows.push_back(mk_row(REQ_EXTRACT, '0, 1, '0, STAT_EMPTY, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].kind, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].result);

    // Short random mix at small sizes, with one long hold-off of the receiver.
    for (int i = 0; i < MIX_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if ($urandom_range(0, 9) < ((i < MIX_ITEMS / 2) ? 3 : 6))
        send_random(REQ_EXTRACT);
      else
        send_random(REQ_INSERT);
    end

    // Fill to capacity, probe the full refusal, and free one slot in between.
    while (heap_fill < CAPACITY) send_random(REQ_INSERT);
    repeat (3) send_random(REQ_INSERT);
    send_random(REQ_EXTRACT);
    repeat (2) send_random(REQ_INSERT);

    // Deep extracts from the full heap with no idling on either side.
    quiet = 1'b1;
    repeat (DRAIN_ITEMS) send_random(REQ_EXTRACT);
    in_tvalid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d inserted, %0d extracted, %0d refused full, %0d refused empty.",
             sent_items, n_inserted, n_extracted, n_full, n_empty);
    $display("Peak occupancy %0d of %0d entries, %0d failures.", peak_fill, CAPACITY, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
